[design/cis_pkg.sv]
// ----------------------------------------------------------------------------
// cis_pkg: shared types and helpers for the CIGAR indel statistics unit
// Holds the op-length width, character codes, the token passed from the
// front end to the back end, and saturating helpers.
// ----------------------------------------------------------------------------
package cis_pkg;

  // Width of op lengths and running sums inside the block
  localparam int LEN_BITS = 24;
  // Width of each result field
  localparam int OUT_BITS = 24;
  // Depth of the token queue between front and back end
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  localparam int CMP_W = (LEN_BITS > OUT_BITS) ? LEN_BITS : OUT_BITS;

  typedef logic [LEN_BITS-1:0] len_t;
  typedef logic [OUT_BITS-1:0] out_t;
  typedef logic [7:0]          char_t;

  localparam len_t LEN_MAX = {LEN_BITS{1'b1}};
  localparam out_t OUT_MAX = {OUT_BITS{1'b1}};

  // ASCII codes the scanner acts on
  localparam char_t CH_0 = 8'h30;
  localparam char_t CH_9 = 8'h39;
  localparam char_t CH_D = 8'h44;
  localparam char_t CH_I = 8'h49;
  localparam char_t CH_M = 8'h4D;
  localparam char_t CH_S = 8'h53;

  // Token kinds; TK_NONE only carries an end-of-read mark
  typedef enum logic [2:0] {
    TK_NONE,
    TK_D,
    TK_I,
    TK_M,
    TK_CLIP
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t kind;
    len_t      len;
    logic      last;
  } token_t;

  // Add two lengths, saturating at the top of the length range
  function automatic len_t sat_add(input len_t a, input len_t b);
    logic [LEN_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[LEN_BITS] ? LEN_MAX : s[LEN_BITS-1:0];
  endfunction

  // Clip a length to the result field range
  function automatic out_t out_clip(input len_t v);
    logic [CMP_W-1:0] w;
    w = CMP_W'(v);
    return (w > CMP_W'(OUT_MAX)) ? OUT_MAX : OUT_BITS'(w);
  endfunction

endpackage

[design/cis_front.sv]
// ----------------------------------------------------------------------------
// cis_front: character scanner
// Accepts one CIGAR character per cycle unless full, builds the decimal op
// length and turns op letters, clips and the end-of-read mark into tokens.
// ----------------------------------------------------------------------------
module cis_front import cis_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  char_t  cigar_char,
  input  logic   last,
  input  logic   push,
  output logic   full,
  input  logic   q_full,
  output logic   tok_push,
  output token_t tok
);

  len_t acc;
  len_t acc_next;
  logic accept;
  logic is_digit;
  logic [LEN_BITS+3:0] acc_wide;

  assign full   = q_full;
  assign accept = push && !q_full;

  // Classify the character and form the token and next accumulator
  always_comb begin
    is_digit = cigar_char inside {[CH_0:CH_9]};
    acc_wide = ({4'b0, acc} << 3) + ({4'b0, acc} << 1)
               + (LEN_BITS+4)'(cigar_char - CH_0);
    acc_next = acc;
    tok.kind = TK_NONE;
    tok.len  = acc;
    tok.last = last;
    if (is_digit) begin
      acc_next = (acc_wide > (LEN_BITS+4)'(LEN_MAX)) ? LEN_MAX : acc_wide[LEN_BITS-1:0];
    end else if (cigar_char == CH_D) begin
      tok.kind = TK_D;
      acc_next = '0;
    end else if (cigar_char == CH_I) begin
      tok.kind = TK_I;
      acc_next = '0;
    end else if (cigar_char == CH_M) begin
      tok.kind = TK_M;
      acc_next = '0;
    end else if (cigar_char == CH_S) begin
      tok.kind = TK_CLIP;
      acc_next = '0;
    end
    // end of read restarts the length
    if (last) begin
      acc_next = '0;
    end
    tok_push = accept && ((tok.kind != TK_NONE) || last);
  end

  // Hold the accumulator between characters
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (accept) begin
      acc <= acc_next;
    end
  end

endmodule

[design/cis_queue.sv]
// ----------------------------------------------------------------------------
// cis_queue: token queue
// Small register queue that decouples the scanner from the statistics
// engine so either side can stall on its own.
// ----------------------------------------------------------------------------
module cis_queue import cis_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   wr_en,
  input  token_t wr_tok,
  output logic   q_full,
  output logic   rd_valid,
  output token_t rd_tok,
  input  logic   rd_take
);

  token_t            entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_wr;
  logic              do_rd;

  assign q_full   = (count == QCNT_W'(QDEPTH));
  assign rd_valid = (count != '0);
  assign rd_tok   = entries[rd_ptr];
  assign do_wr    = wr_en && !q_full;
  assign do_rd    = rd_take && rd_valid;

  // Store incoming tokens
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_tok;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(do_wr) - QCNT_W'(do_rd);
    end
  end

endmodule

[design/cis_back.sv]
// ----------------------------------------------------------------------------
// cis_back: statistics engine
// Applies one token per cycle to the per-read sums, longest ops and bridged
// runs; at each read end it loads the result register once that is free.
// ----------------------------------------------------------------------------
module cis_back import cis_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       bridge_length_we,
  input  logic [7:0] bridge_length,
  input  logic       tok_valid,
  input  token_t     tok,
  output logic       tok_take,
  output logic       empty,
  input  logic       pop,
  output out_t       total_insertion,
  output out_t       total_deletion,
  output out_t       max_deletion,
  output out_t       max_insertion,
  output out_t       max_deletion_bridged,
  output out_t       max_insertion_bridged
);

  logic [7:0] bridge;
  len_t       sum_ins, sum_ins_next;
  len_t       sum_del, sum_del_next;
  len_t       best_single [2];
  len_t       best_single_next [2];
  len_t       run_length [2];
  len_t       run_length_next [2];
  len_t       best_run [2];
  len_t       best_run_next [2];
  logic [1:0] in_run, in_run_next;
  logic       clip_seen, clip_seen_next;
  logic       scan_stopped, scan_stopped_next;
  logic       out_valid;
  logic       is_op;
  logic       is_kind;
  len_t       run_sum;

  assign empty    = !out_valid;
  assign tok_take = tok_valid && (!tok.last || !out_valid || pop);

  // Work out the state after this token
  always_comb begin
    sum_ins_next      = sum_ins;
    sum_del_next      = sum_del;
    in_run_next       = in_run;
    clip_seen_next    = clip_seen;
    scan_stopped_next = scan_stopped;
    is_kind           = 1'b0;
    run_sum           = '0;
    for (int k = 0; k < 2; k++) begin
      best_single_next[k] = best_single[k];
      run_length_next[k]  = run_length[k];
      best_run_next[k]    = best_run[k];
    end
    is_op = tok.kind inside {TK_D, TK_I, TK_M};
    if (tok.kind == TK_D) begin
      sum_del_next = sat_add(sum_del, tok.len);
    end
    if (tok.kind == TK_I) begin
      sum_ins_next = sat_add(sum_ins, tok.len);
    end
    if (is_op && !scan_stopped) begin
      for (int k = 0; k < 2; k++) begin
        is_kind = (k == 0) ? (tok.kind == TK_D) : (tok.kind == TK_I);
        run_sum = sat_add(run_length[k], tok.len);
        if (is_kind) begin
          if (tok.len > best_single[k]) begin
            best_single_next[k] = tok.len;
          end
          run_length_next[k] = run_sum;
          in_run_next[k]     = 1'b1;
          if (run_sum > best_run[k]) begin
            best_run_next[k] = run_sum;
          end
        end else begin
          // a separator of bridge length keeps the run alive
          if (in_run[k] && (tok.len == len_t'(bridge))) begin
            run_length_next[k] = run_sum;
          end else begin
            run_length_next[k] = '0;
          end
          in_run_next[k] = 1'b0;
        end
      end
    end
    // first clip drops runs in progress, second clip stops the scan
    if ((tok.kind == TK_CLIP) && !scan_stopped) begin
      if (clip_seen) begin
        scan_stopped_next = 1'b1;
      end else begin
        clip_seen_next = 1'b1;
        in_run_next    = '0;
        for (int k = 0; k < 2; k++) begin
          run_length_next[k] = '0;
        end
      end
    end
  end

  // Hold the bridge length register
  always_ff @(posedge clk) begin
    if (rst) begin
      bridge <= 8'd1;
    end else if (bridge_length_we) begin
      bridge <= bridge_length;
    end
  end

  // Update per-read state; clear it at the end of each read
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_ins      <= '0;
      sum_del      <= '0;
      in_run       <= '0;
      clip_seen    <= 1'b0;
      scan_stopped <= 1'b0;
      for (int k = 0; k < 2; k++) begin
        best_single[k] <= '0;
        run_length[k]  <= '0;
        best_run[k]    <= '0;
      end
    end else if (tok_take) begin
      if (tok.last) begin
        sum_ins      <= '0;
        sum_del      <= '0;
        in_run       <= '0;
        clip_seen    <= 1'b0;
        scan_stopped <= 1'b0;
        for (int k = 0; k < 2; k++) begin
          best_single[k] <= '0;
          run_length[k]  <= '0;
          best_run[k]    <= '0;
        end
      end else begin
        sum_ins      <= sum_ins_next;
        sum_del      <= sum_del_next;
        in_run       <= in_run_next;
        clip_seen    <= clip_seen_next;
        scan_stopped <= scan_stopped_next;
        for (int k = 0; k < 2; k++) begin
          best_single[k] <= best_single_next[k];
          run_length[k]  <= run_length_next[k];
          best_run[k]    <= best_run_next[k];
        end
      end
    end
  end

  // Track the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (tok_take && tok.last) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // Load the result fields
  always_ff @(posedge clk) begin
    if (tok_take && tok.last) begin
      total_insertion       <= out_clip(sum_ins_next);
      total_deletion        <= out_clip(sum_del_next);
      max_deletion          <= out_clip(best_single_next[0]);
      max_insertion         <= out_clip(best_single_next[1]);
      max_deletion_bridged  <= out_clip(best_run_next[0]);
      max_insertion_bridged <= out_clip(best_run_next[1]);
    end
  end

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    tok_take && tok.last |=> !empty)
    else $error("result not loaded after end of read");

  a_stop_after_clip: assert property (@(posedge clk) disable iff (rst)
    scan_stopped |-> clip_seen)
    else $error("scan stopped without a first clip");

  a_one_run_open: assert property (@(posedge clk) disable iff (rst)
    !(in_run[0] && in_run[1]))
    else $error("deletion and insertion runs open at once");

  a_single_le_run: assert property (@(posedge clk) disable iff (rst)
    (best_single[0] <= best_run[0]) && (best_single[1] <= best_run[1]))
    else $error("longest op exceeds longest bridged run");

endmodule

[design/cigar_indel_statistics_unit.sv]
// ----------------------------------------------------------------------------
// cigar_indel_statistics_unit: per-read indel statistics from CIGAR text
// Input queue side: drive cigar_char and last with push; a request is
// taken at a clock edge where push is high and full is low. Mark the final
// character of each read's CIGAR with last.
// Result queue side: while empty is low the six statistics of the oldest
// finished read are on the result ports; pop at an edge with empty low takes
// them. One result is produced per read.
// bridge_length_we writes bridge_length at any edge; write it only while no
// read is in flight.
// Throughput: one request per cycle while full is low, set by the scanner's
// multiply-by-ten add and the one-token-per-cycle statistics engine.
// Result path: a read's last request is stored as a token in the token queue;
// the engine then takes it and loads the result register, and empty falls.
// When pop is held off, the finished result waits in the result register;
// the next read's tokens keep flowing until its end-of-read token reaches
// the head, then the four-entry token queue fills and full rises.
// Reset clears all per-read state and sets the stored bridge length to 1.
// ----------------------------------------------------------------------------
module cigar_indel_statistics_unit import cis_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] cigar_char,
  input  logic       last,
  input  logic       push,
  output logic       full,
  input  logic       bridge_length_we,
  input  logic [7:0] bridge_length,
  output logic       empty,
  input  logic       pop,
  output out_t       total_insertion,
  output out_t       total_deletion,
  output out_t       max_deletion,
  output out_t       max_insertion,
  output out_t       max_deletion_bridged,
  output out_t       max_insertion_bridged
);

  logic   q_full;
  logic   tok_push;
  token_t tok_in;
  logic   tok_valid;
  token_t tok_out;
  logic   tok_take;

  // Scan characters into tokens
  cis_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cigar_char (cigar_char),
    .last       (last),
    .push       (push),
    .full       (full),
    .q_full     (q_full),
    .tok_push   (tok_push),
    .tok        (tok_in)
  );

  // Buffer tokens between the two halves
  cis_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (tok_push),
    .wr_tok   (tok_in),
    .q_full   (q_full),
    .rd_valid (tok_valid),
    .rd_tok   (tok_out),
    .rd_take  (tok_take)
  );

  // Apply tokens and present results
  cis_back u_back (
    .clk                   (clk),
    .rst                   (rst),
    .bridge_length_we      (bridge_length_we),
    .bridge_length         (bridge_length),
    .tok_valid             (tok_valid),
    .tok                   (tok_out),
    .tok_take              (tok_take),
    .empty                 (empty),
    .pop                   (pop),
    .total_insertion       (total_insertion),
    .total_deletion        (total_deletion),
    .max_deletion          (max_deletion),
    .max_insertion         (max_insertion),
    .max_deletion_bridged  (max_deletion_bridged),
    .max_insertion_bridged (max_insertion_bridged)
  );

endmodule
